// ===== hw/rtl/rgb_to_hsl_converter_defines.svh =====
// assertion macros for the rgb to hsl converter
`ifndef RGB_TO_HSL_CONVERTER_DEFINES_SVH
`define RGB_TO_HSL_CONVERTER_DEFINES_SVH

`ifndef SYNTHESIS
// same-cycle implication
`define RTH_ASSERT_NOW(label, clk, rst, pre, post) \
   label: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) \
      else $error("rth assertion failed");
// next-cycle implication
`define RTH_ASSERT_NEXT(label, clk, rst, pre, post) \
   label: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
      else $error("rth assertion failed");
`else
`define RTH_ASSERT_NOW(label, clk, rst, pre, post)
`define RTH_ASSERT_NEXT(label, clk, rst, pre, post)
`endif

`endif

// ===== hw/rtl/rth_pkg.sv =====
package rth_pkg;

   localparam int CH_W    = 8;
   localparam int HUE_W   = 16;
   localparam int SAT_W   = 17;
   localparam int LIGHT_W = 17;

   // divider operands: numerator and denominator up to 6 * 255
   localparam int DIV_W           = 11;
   localparam int QUO_W           = 17;
   localparam int STEPS_PER_STAGE = 2;
   localparam int DIV_STAGES      = (QUO_W + STEPS_PER_STAGE - 1) / STEPS_PER_STAGE;
   localparam int FRONT_STAGES    = 2;
   localparam int NUM_STAGES      = FRONT_STAGES + DIV_STAGES;

   localparam logic [DIV_W-1:0] LIGHT_DEN = DIV_W'(510);
   localparam logic [DIV_W-1:0] SAT_SPLIT = DIV_W'(255);

   typedef struct packed {
      logic             bit_q;
      logic [DIV_W-1:0] rem;
   } div_step_type;

   // one restoring step, x below twice den
   function automatic div_step_type div_step(input logic [DIV_W:0] x,
                                             input logic [DIV_W-1:0] den);
      div_step_type res;
      logic [DIV_W:0] diff;
      diff = x - {1'b0, den};
      if (x >= {1'b0, den}) begin
         res.bit_q = 1'b1;
         res.rem   = diff[DIV_W-1:0];
      end else begin
         res.bit_q = 1'b0;
         res.rem   = x[DIV_W-1:0];
      end
      return res;
   endfunction

endpackage

// ===== hw/rtl/rth_req_if.sv =====
interface rth_req_if import rth_pkg::*;;
   logic            valid;
   logic            ready;
   logic [CH_W-1:0] red;
   logic [CH_W-1:0] green;
   logic [CH_W-1:0] blue;

   modport source (output valid, output red, output green, output blue, input ready);
   modport sink (input valid, input red, input green, input blue, output ready);
endinterface

// ===== hw/rtl/rth_rsp_if.sv =====
interface rth_rsp_if import rth_pkg::*;;
   logic               valid;
   logic               ready;
   logic [HUE_W-1:0]   hue;
   logic [SAT_W-1:0]   saturation;
   logic [LIGHT_W-1:0] lightness;

   modport source (output valid, output hue, output saturation, output lightness,
                   input ready);
   modport sink (input valid, input hue, input saturation, input lightness,
                 output ready);
endinterface

// ===== hw/rtl/rth_front.sv =====
module rth_front import rth_pkg::*; (
   input  logic                    clock,
   input  logic [FRONT_STAGES-1:0] stage_en,
   input  logic [CH_W-1:0]         red,
   input  logic [CH_W-1:0]         green,
   input  logic [CH_W-1:0]         blue,
   output logic [DIV_W-1:0]        hue_num,
   output logic [DIV_W-1:0]        hue_den,
   output logic [DIV_W-1:0]        sat_num,
   output logic [DIV_W-1:0]        sat_den,
   output logic [LIGHT_W-1:0]      light
);

   typedef enum logic [1:0] {
      SECT_RED,
      SECT_GREEN,
      SECT_BLUE
   } sector_type;

   // stage one: max, min, sector and signed color difference
   sector_type      sect_in, sect_ff;
   logic [CH_W-1:0] mx_in, mx_ff, mn_in, mn_ff;
   logic [CH_W:0]   diff_in, diff_ff;

   always_comb begin
      if (red >= green && red >= blue) begin
         sect_in = SECT_RED;
         mx_in   = red;
         diff_in = {1'b0, green} - {1'b0, blue};
      end else if (green >= blue) begin
         sect_in = SECT_GREEN;
         mx_in   = green;
         diff_in = {1'b0, blue} - {1'b0, red};
      end else begin
         sect_in = SECT_BLUE;
         mx_in   = blue;
         diff_in = {1'b0, red} - {1'b0, green};
      end
      if (red <= green && red <= blue) begin
         mn_in = red;
      end else if (green <= blue) begin
         mn_in = green;
      end else begin
         mn_in = blue;
      end
   end

   always_ff @(posedge clock) begin
      if (stage_en[0]) begin
         sect_ff <= sect_in;
         mx_ff   <= mx_in;
         mn_ff   <= mn_in;
         diff_ff <= diff_in;
      end
   end

   // stage two: divider operands and the finished lightness
   logic [CH_W-1:0]    d;
   logic [CH_W:0]      s;
   logic [DIV_W-1:0]   d6, base;
   logic [DIV_W:0]     n_wide;
   logic               gray;
   logic [DIV_W-1:0]   hue_num_in, hue_num_ff, hue_den_in, hue_den_ff;
   logic [DIV_W-1:0]   sat_num_in, sat_num_ff, sat_den_in, sat_den_ff;
   logic [LIGHT_W-2:0] light_y;
   logic [LIGHT_W-1:0] light_sum;
   logic [LIGHT_W-1:0] light_in, light_ff;

   always_comb begin
      d    = mx_ff - mn_ff;
      s    = {1'b0, mx_ff} + {1'b0, mn_ff};
      d6   = {1'b0, d, 2'b00} + {2'b00, d, 1'b0};
      gray = (d == '0);
      case (sect_ff)
         SECT_RED:   base = diff_ff[CH_W] ? d6 : '0;
         SECT_GREEN: base = {2'b00, d, 1'b0};
         SECT_BLUE:  base = {1'b0, d, 2'b00};
         default:    base = '0;
      endcase
      // result is never negative after the wrap above
      n_wide       = {1'b0, base} + {{(DIV_W - CH_W){diff_ff[CH_W]}}, diff_ff};
      hue_num_in   = n_wide[DIV_W-1:0];
      hue_den_in   = gray ? DIV_W'(1) : d6;
      sat_num_in   = {{(DIV_W - CH_W){1'b0}}, d};
      if (gray) begin
         sat_den_in = DIV_W'(1);
      end else if ({{(DIV_W - CH_W - 1){1'b0}}, s} < SAT_SPLIT) begin
         sat_den_in = {{(DIV_W - CH_W - 1){1'b0}}, s};
      end else begin
         sat_den_in = LIGHT_DEN - {{(DIV_W - CH_W - 1){1'b0}}, s};
      end
      // s * 65536 / 510 = 128 s + 128 s / 255, and y / 255 is
      // (y + (y >> 8) + 1) >> 8, exact for y up to 255 * 256
      light_y   = {s, {(LIGHT_W - CH_W - 2){1'b0}}};
      light_sum = {1'b0, light_y} + {{(CH_W + 1){1'b0}}, light_y[LIGHT_W-2:CH_W]}
                  + LIGHT_W'(1);
      light_in  = {1'b0, light_y} + {{CH_W{1'b0}}, light_sum[LIGHT_W-1:CH_W]};
   end

   always_ff @(posedge clock) begin
      if (stage_en[1]) begin
         hue_num_ff <= hue_num_in;
         hue_den_ff <= hue_den_in;
         sat_num_ff <= sat_num_in;
         sat_den_ff <= sat_den_in;
         light_ff   <= light_in;
      end
   end

   assign hue_num = hue_num_ff;
   assign hue_den = hue_den_ff;
   assign sat_num = sat_num_ff;
   assign sat_den = sat_den_ff;
   assign light   = light_ff;

endmodule

// ===== hw/rtl/rth_div.sv =====
module rth_div import rth_pkg::*; (
   input  logic                  clock,
   input  logic [DIV_STAGES-1:0] stage_en,
   input  logic [DIV_W-1:0]      num,
   input  logic [DIV_W-1:0]      den,
   output logic [QUO_W-1:0]      quo
);

   // computes floor(num * 2^(QUO_W-1) / den) for num <= den, msb first
   logic [DIV_W:0]   x_ff   [DIV_STAGES];
   logic [DIV_W-1:0] den_ff [DIV_STAGES];
   logic [QUO_W-1:0] q_ff   [DIV_STAGES];

   for (genvar i = 0; i < DIV_STAGES; i++) begin : g_stage
      logic [DIV_W:0]   x_src, x_in;
      logic [DIV_W-1:0] den_src;
      logic [QUO_W-1:0] q_src, q_in;

      if (i == 0) begin : g_first
         assign x_src   = {1'b0, num};
         assign den_src = den;
         assign q_src   = '0;
      end else begin : g_next
         assign x_src   = x_ff[i-1];
         assign den_src = den_ff[i-1];
         assign q_src   = q_ff[i-1];
      end

      always_comb begin
         div_step_type st;
         x_in = x_src;
         q_in = q_src;
         for (int j = 0; j < STEPS_PER_STAGE; j++) begin
            if (i * STEPS_PER_STAGE + j < QUO_W) begin
               st   = div_step(x_in, den_src);
               q_in = {q_in[QUO_W-2:0], st.bit_q};
               x_in = {st.rem, 1'b0};
            end
         end
      end

      always_ff @(posedge clock) begin
         if (stage_en[i]) begin
            x_ff[i]   <= x_in;
            den_ff[i] <= den_src;
            q_ff[i]   <= q_in;
         end
      end
   end

   assign quo = q_ff[DIV_STAGES-1];

endmodule

// ===== hw/rtl/rgb_to_hsl_converter.sv =====
// rgb to hsl converter: takes one 8-bit rgb pixel per request and returns hue,
// saturation and lightness as unsigned fixed point with 65536 = 1.0 (hue in
// turns, wraps below one turn), each truncated from the exact quotient. gray
// pixels give zero hue and saturation; on a tied maximum red wins over green
// and green over blue. throughput is one pixel per clock unless the output
// stalls; each pixel passes two operand stages plus nine divider stages, the
// divider count set by the 17-bit quotient retired two bits per stage. every
// stage holds its own valid bit and moves when the stage after it is free, so
// bubbles close up under a stalled output and the input stays open meanwhile
`include "rgb_to_hsl_converter_defines.svh"

module rgb_to_hsl_converter import rth_pkg::*; (
   input logic   clock,
   input logic   reset,
   rth_req_if.sink   req_bus,
   rth_rsp_if.source rsp_bus
);

   // per-stage valid bits and advance enables
   logic [NUM_STAGES-1:0] v_ff, v_in;
   logic [NUM_STAGES-1:0] stage_en;

   // a stage advances when it is empty or the stage after it advances
   always_comb begin
      stage_en[NUM_STAGES-1] = !v_ff[NUM_STAGES-1] || rsp_bus.ready;
      for (int i = NUM_STAGES - 2; i >= 0; i--) begin
         stage_en[i] = !v_ff[i] || stage_en[i+1];
      end
   end

   assign v_in = (stage_en & {v_ff[NUM_STAGES-2:0], req_bus.valid}) | (~stage_en & v_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= '0;
      end else begin
         v_ff <= v_in;
      end
   end

   assign req_bus.ready = stage_en[0];
   assign rsp_bus.valid = v_ff[NUM_STAGES-1];

   // operand stages: max/min, sector, then numerators, denominators and lightness
   logic [DIV_W-1:0]   hue_num, hue_den, sat_num, sat_den;
   logic [LIGHT_W-1:0] light;

   rth_front u_front (
      .clock     (clock),
      .stage_en  (stage_en[FRONT_STAGES-1:0]),
      .red       (req_bus.red),
      .green     (req_bus.green),
      .blue      (req_bus.blue),
      .hue_num   (hue_num),
      .hue_den   (hue_den),
      .sat_num   (sat_num),
      .sat_den   (sat_den),
      .light     (light)
   );

   // two dividers run in lockstep on the same enables
   logic [QUO_W-1:0] hue_quo, sat_quo;

   rth_div u_div_hue (
      .clock    (clock),
      .stage_en (stage_en[NUM_STAGES-1:FRONT_STAGES]),
      .num      (hue_num),
      .den      (hue_den),
      .quo      (hue_quo)
   );

   rth_div u_div_sat (
      .clock    (clock),
      .stage_en (stage_en[NUM_STAGES-1:FRONT_STAGES]),
      .num      (sat_num),
      .den      (sat_den),
      .quo      (sat_quo)
   );

   // lightness is done after the operand stages, it just rides along the divider stages
   logic [LIGHT_W-1:0] light_pipe_ff [DIV_STAGES];

   always_ff @(posedge clock) begin
      if (stage_en[FRONT_STAGES]) begin
         light_pipe_ff[0] <= light;
      end
      for (int i = 1; i < DIV_STAGES; i++) begin
         if (stage_en[FRONT_STAGES + i]) begin
            light_pipe_ff[i] <= light_pipe_ff[i-1];
         end
      end
   end

   // hue numerator stays below its denominator, so the top bit is always clear
   assign rsp_bus.hue        = hue_quo[HUE_W-1:0];
   assign rsp_bus.saturation = sat_quo[SAT_W-1:0];
   assign rsp_bus.lightness  = light_pipe_ff[DIV_STAGES-1];

   // an accepted request always lands in the first stage
   `RTH_ASSERT_NEXT(a_req_enters, clock, reset, req_bus.valid && req_bus.ready, v_ff[0])

   // zero saturation only for gray, and gray has zero hue
   `RTH_ASSERT_NOW(a_gray_hue, clock, reset,
      rsp_bus.valid && rsp_bus.saturation == '0, rsp_bus.hue == '0)

   // saturation never exceeds one
   `RTH_ASSERT_NOW(a_sat_range, clock, reset,
      rsp_bus.valid && rsp_bus.saturation[SAT_W-1], rsp_bus.saturation[SAT_W-2:0] == '0)

   // full lightness is white, which carries no saturation
   `RTH_ASSERT_NOW(a_white, clock, reset,
      rsp_bus.valid && rsp_bus.lightness[LIGHT_W-1], rsp_bus.saturation == '0)

endmodule
